// ----- design/rdft10_pkg.sv -----
// ----------------------------------------------------------------------------
// rdft10_pkg
// Widths, types, coefficients and helpers shared by the ten-point real DFT.
// ----------------------------------------------------------------------------
package rdft10_pkg;

  // Transform size and sample width
  localparam int NPTS         = 10;
  localparam int SAMPLE_WIDTH = 16;

  // Number of register stages in the datapath
  localparam int NSTG = 4;

  // Number of constant products and of pass-through terms per item
  localparam int NPROD = 12;
  localparam int NPASS = 4;

  // Fixed-point coefficient format: Q2.16
  localparam int QFRAC = 16;
  localparam int CW    = 18;

  // Datapath widths
  localparam int AW = SAMPLE_WIDTH + 1;  // first butterfly level
  localparam int SW = SAMPLE_WIDTH + 3;  // second level, multiplier operands
  localparam int PW = SW + CW;           // full product
  localparam int QW = PW - QFRAC;        // product back at integer scale
  localparam int FW = QW + 3;            // final sums before saturation
  localparam int OW = 21;                // result word

  // Stream packing
  localparam int IN_TDATA_W  = ((NPTS * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((NPTS * OW + 7) / 8) * 8;

  // Result range
  localparam int OUT_MAX = (2 ** (OW - 1)) - 1;
  localparam int OUT_MIN = -(2 ** (OW - 1));

  // Direction codes
  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_BWD = 1'b1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [AW-1:0]           bfly_t;
  typedef logic signed [SW-1:0]           opnd_t;
  typedef logic signed [CW-1:0]           coef_t;
  typedef logic signed [PW-1:0]           prod_t;
  typedef logic signed [QW-1:0]           prodq_t;
  typedef logic signed [FW-1:0]           full_t;
  typedef logic signed [OW-1:0]           result_t;

  // Control that travels with an item into the datapath
  typedef struct packed {
    logic valid;
    logic dir;
  } item_ctl_t;

  // Q2.16 coefficients, rounded to nearest
  localparam int C_F1 = 36636;   // 0.559017
  localparam int C_F2 = 16384;   // 0.25
  localparam int C_F3 = 38521;   // 0.587785
  localparam int C_F4 = 62328;   // 0.951057
  localparam int C_B1 = 73271;   // 1.118034
  localparam int C_B2 = 32768;   // 0.5
  localparam int C_B4 = 77042;   // 1.175571
  localparam int C_B5 = 124657;  // 1.902113

  // Rounding offset added before the product is shifted down
  localparam prod_t RND_HALF = PW'(2 ** (QFRAC - 1));

  // Coefficient of each multiplier slot, per direction
  localparam coef_t COEF_FWD [NPROD] = '{
    CW'(C_F2), CW'(C_F1), CW'(C_F2), CW'(C_F1), CW'(C_F3), CW'(C_F4),
    CW'(C_F3), CW'(C_F4), CW'(C_F4), CW'(C_F3), CW'(C_F4), CW'(C_F3)
  };
  localparam coef_t COEF_BWD [NPROD] = '{
    CW'(C_B2), CW'(C_B1), CW'(C_B2), CW'(C_B1), CW'(C_B4), CW'(C_B5),
    CW'(C_B5), CW'(C_B4), CW'(C_B4), CW'(C_B5), CW'(C_B4), CW'(C_B5)
  };

  // Sample pairing of the first butterfly level, per direction
  localparam int PAIR_FWD_X [NPTS/2] = '{0, 1, 2, 4, 7};
  localparam int PAIR_FWD_Y [NPTS/2] = '{5, 9, 3, 6, 8};
  localparam int PAIR_BWD_X [NPTS/2] = '{0, 1, 2, 3, 4};
  localparam int PAIR_BWD_Y [NPTS/2] = '{9, 7, 8, 5, 6};

  // Clamp a final sum to the result range
  function automatic result_t sat_out(input full_t x);
    full_t y;
    y = x;
    if (x > FW'(OUT_MAX)) y = FW'(OUT_MAX);
    if (x < FW'(OUT_MIN)) y = FW'(OUT_MIN);
    return y[OW-1:0];
  endfunction

endpackage

// ----- design/rdft10_pipe.sv -----
// ----------------------------------------------------------------------------
// rdft10_pipe
// Four-stage datapath: butterflies, second-level sums, shared constant
// multipliers, final combine with saturation. Stall-safe valid chain.
// ----------------------------------------------------------------------------
module rdft10_pipe (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rdft10_pkg::item_ctl_t in_ctl,
  output logic                  in_ready,
  input  rdft10_pkg::sample_t   samples [rdft10_pkg::NPTS],
  output logic                  out_valid,
  input  logic                  out_ready,
  output rdft10_pkg::result_t   results [rdft10_pkg::NPTS]
);
  import rdft10_pkg::*;

  logic [NSTG-1:0] v_r, v_nxt;
  logic [NSTG-2:0] dir_r;
  logic [NSTG-1:0] adv;

  bfly_t   a_r    [NPTS];
  bfly_t   a_nxt  [NPTS];
  opnd_t   op_r   [NPROD];
  opnd_t   op_nxt [NPROD];
  opnd_t   ps_r   [NPASS];
  opnd_t   ps_nxt [NPASS];
  prodq_t  m_r    [NPROD];
  prodq_t  m_nxt  [NPROD];
  opnd_t   p_r    [NPASS];
  result_t res_r  [NPTS];
  result_t res_nxt[NPTS];

  // Stage advance: a stage loads when it is empty or the next one moves
  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    v_nxt = v_r;
    if (adv[0]) v_nxt[0] = in_ctl.valid;
    for (int k = 1; k < NSTG; k++) begin
      if (adv[k]) v_nxt[k] = v_r[k-1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NSTG-1];
  assign results   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Stage 0: first butterfly level, pairing set by direction
  always_comb begin
    sample_t x;
    sample_t y;
    for (int j = 0; j < NPTS / 2; j++) begin
      x = (in_ctl.dir == DIR_BWD) ? samples[PAIR_BWD_X[j]] : samples[PAIR_FWD_X[j]];
      y = (in_ctl.dir == DIR_BWD) ? samples[PAIR_BWD_Y[j]] : samples[PAIR_FWD_Y[j]];
      a_nxt[2*j]   = AW'(x) + AW'(y);
      a_nxt[2*j+1] = AW'(x) - AW'(y);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a_r      <= a_nxt;
      dir_r[0] <= in_ctl.dir;
    end
  end

  // Stage 1: second-level sums and multiplier operand routing
  always_comb begin
    opnd_t e [NPTS];
    opnd_t s10, s11, s12, s13, s14, s15, s16, s17, s18, s19, s20, s21;
    opnd_t b10, b11, b12, b13;
    for (int i = 0; i < NPTS; i++) begin
      e[i] = SW'(a_r[i]);
    end
    // forward network
    s10 = e[2] + e[6];
    s14 = e[4] + e[8];
    s18 = s10 + s14;
    s19 = s10 - s14;
    s11 = e[2] - e[6];
    s17 = e[5] - e[9];
    s20 = s11 + s17;
    s21 = s11 - s17;
    s12 = e[3] + e[7];
    s13 = e[7] - e[3];
    s15 = e[4] - e[8];
    s16 = e[5] + e[9];
    // backward network
    b10 = e[2] + e[6];
    b11 = e[2] - e[6];
    b12 = e[3] + e[7];
    b13 = e[3] - e[7];
    if (dir_r[0] == DIR_BWD) begin
      op_nxt = '{b10, b11, b13, b12, e[8], e[4], e[9], e[5], e[4], e[8], e[9], e[5]};
      ps_nxt = '{e[0], e[1], b10, b13};
    end else begin
      op_nxt = '{s21, s20, s18, s19, s12, s15, s15, s12, s16, s13, s13, s16};
      ps_nxt = '{e[0], e[1], s18, s21};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      op_r     <= op_nxt;
      ps_r     <= ps_nxt;
      dir_r[1] <= dir_r[0];
    end
  end

  // Stage 2: twelve constant multipliers, rounded to nearest (ties up)
  always_comb begin
    prod_t prod;
    prod_t rnd;
    coef_t c;
    for (int k = 0; k < NPROD; k++) begin
      c        = (dir_r[1] == DIR_BWD) ? COEF_BWD[k] : COEF_FWD[k];
      prod     = PW'(op_r[k]) * PW'(c);
      rnd      = prod + RND_HALF;
      m_nxt[k] = rnd[PW-1:QFRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      m_r      <= m_nxt;
      p_r      <= ps_r;
      dir_r[2] <= dir_r[1];
    end
  end

  // Stage 3: output combine and saturation
  always_comb begin
    full_t mx [NPROD];
    full_t px [NPASS];
    full_t of [NPTS];
    full_t ob [NPTS];
    full_t t26, t27;
    full_t m34, m35, m36, m37, s18, s19, s20, s21, s22, s23;
    for (int k = 0; k < NPROD; k++) mx[k] = FW'(m_r[k]);
    for (int k = 0; k < NPASS; k++) px[k] = FW'(p_r[k]);
    // forward
    of[0] = px[0] + px[2];
    of[9] = px[1] - px[3];
    t26   = mx[0] + px[1];
    of[1] = t26 + mx[1];
    of[5] = t26 - mx[1];
    of[2] = -(mx[4] + mx[5]);
    of[6] = mx[6] - mx[7];
    of[8] = mx[8] + mx[9];
    of[4] = mx[10] - mx[11];
    t27   = px[0] - mx[2];
    of[3] = t27 + mx[3];
    of[7] = t27 - mx[3];
    // backward
    ob[5] = px[1] - (px[3] <<< 1);
    ob[0] = px[0] + (px[2] <<< 1);
    m36   = mx[4] - mx[5];
    m37   = mx[6] - mx[7];
    m34   = mx[8] + mx[9];
    m35   = mx[10] + mx[11];
    s19   = px[0] - mx[0];
    s22   = s19 + mx[1];
    s23   = s19 - mx[1];
    s18   = px[1] + mx[2];
    s20   = s18 + mx[3];
    s21   = s18 - mx[3];
    ob[4] = s23 + m37;
    ob[6] = s23 - m37;
    ob[3] = s21 + m36;
    ob[7] = s21 - m36;
    ob[1] = s20 - m34;
    ob[9] = s20 + m34;
    ob[2] = s22 - m35;
    ob[8] = s22 + m35;
    for (int i = 0; i < NPTS; i++) begin
      res_nxt[i] = sat_out((dir_r[2] == DIR_BWD) ? ob[i] : of[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      res_r <= res_nxt;
    end
  end

  // Checks
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("pipeline not empty after reset");

  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    ((&v_r) && !out_ready) |-> !in_ready)
    else $error("input accepted while pipeline full and stalled");

  a_dir_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[1] && adv[2]) |=> (dir_r[2] == $past(dir_r[1])))
    else $error("direction lost between operand and product stages");

  a_prod_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[2] && !adv[2]) |=> (v_r[2] && $stable(dir_r[2])))
    else $error("stalled product stage changed");

endmodule

// ----- design/real_dft_10_point.sv -----
// ----------------------------------------------------------------------------
// real_dft_10_point
// Ten-point real DFT, forward (real to halfcomplex) or backward (halfcomplex
// to real, unnormalised), fixed point, one transform per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction carries ten signed 16-bit samples.
//   out_* : one transaction carries ten signed 21-bit saturated words.
//   cfg_* : write of the direction bit (0 forward, 1 backward); always ready.
//           Write it only while no transform is in flight.
// Pipeline: each input passes the butterfly, sum, multiply and combine
//   register stages before its result transaction is offered.
// Throughput: one transform per cycle unless stalled; every stage loads
//   whenever its successor moves, so a full pipeline streams with no bubbles.
// Stall: when out_tready is low the last stage holds; earlier stages keep
//   filling empty slots, and in_tready drops once all four stages are full.
// Reset (rst_n low, synchronous): pipeline emptied, direction set to forward.
// ----------------------------------------------------------------------------
module real_dft_10_point (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // sample_0 [15:0], sample_1 ... sample_9 [159:144]
  input  logic [rdft10_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // result_0 [20:0], result_1 ... result_9 [209:189], zero pad [215:210]
  output logic [rdft10_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Direction register write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_data
);
  import rdft10_pkg::*;

  logic      direction_r;
  sample_t   samples [NPTS];
  result_t   results [NPTS];
  item_ctl_t in_ctl;

  // Direction register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_FWD;
    end else if (cfg_valid && cfg_ready) begin
      direction_r <= cfg_data;
    end
  end

  // Unpack samples, pack results
  for (genvar i = 0; i < NPTS; i++) begin : g_lanes
    assign samples[i]                = in_tdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    assign out_tdata[i*OW +: OW]     = results[i];
  end

  if (OUT_TDATA_W > NPTS * OW) begin : g_pad
    assign out_tdata[OUT_TDATA_W-1:NPTS*OW] = '0;
  end

  assign in_ctl.valid = in_tvalid;
  assign in_ctl.dir   = direction_r;

  rdft10_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (in_ctl),
    .in_ready  (in_tready),
    .samples   (samples),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .results   (results)
  );

endmodule
